### src/gbt_pkg.sv
// Package: shared constants and types for the graph traversal unit.
package gbt_pkg;

   localparam int MAX_VERTICES_DEF = 32;
   localparam int MAX_DEGREE_DEF   = 8;
   localparam int RESULT_CAP       = 32;
   localparam int CNT_W            = 6;
   localparam int CFG_W            = 6;
   localparam int FIELD_W          = 5;
   localparam int CFG_RESET        = 32;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_BFS = 2'd1,
      OP_DFS = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_VISIT   = 2'd0,
      ST_ADDED   = 2'd1,
      ST_DROPPED = 2'd2,
      ST_RANGE   = 2'd3
   } status_type;

   typedef struct packed {
      logic               valid;
      logic [1:0]         status;
      logic [FIELD_W-1:0] vertex;
      logic               last;
   } emit_type;

endpackage

### src/gbt_ram.sv
// Generic simple dual-port RAM with registered read.
module gbt_ram
   import gbt_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/gbt_engine.sv
// Sequencer for edge insertion and breadth/depth-first traversal.
module gbt_engine
   import gbt_pkg::*;
#(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF,
   parameter int MAX_DEGREE   = MAX_DEGREE_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [CFG_W-1:0]   vertex_count,
   input  logic               start,
   input  logic [1:0]         op,
   input  logic [FIELD_W-1:0] edge_source,
   input  logic [FIELD_W-1:0] edge_destination,
   input  logic [FIELD_W-1:0] root_vertex,
   output logic               idle,
   input  logic               out_free,
   output emit_type           emit
);

   localparam int VW = $clog2(MAX_VERTICES);
   localparam int DW = $clog2(MAX_DEGREE + 1);
   localparam int AW = $clog2(MAX_VERTICES * MAX_DEGREE);
   localparam int NW = CFG_W + 1;
   localparam int PW = VW + DW;

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_ADD_RD, S_ADD_CHK, S_ADD_WD, S_RESULT,
      S_B_POP, S_B_POPW, S_B_NREAD, S_B_NCHK,
      S_D_TOP, S_D_TOPW, S_D_NCHK, S_FINISH
   } state_type;

   state_type          state_ff, state_in;
   logic [1:0]         op_ff, op_in;
   logic [FIELD_W-1:0] src_ff, src_in, dst_ff, dst_in, root_ff, root_in;
   logic [1:0]         status_ff, status_in;
   logic [VW-1:0]      v_ff, v_in;
   logic [DW-1:0]      pos_ff, pos_in;
   logic [DW-1:0]      degs_ff, degs_in;
   logic [VW:0]        head_ff, head_in, tail_ff, tail_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               hold_vld_ff, hold_vld_in;
   logic [VW-1:0]      hold_v_ff, hold_v_in;
   logic [MAX_VERTICES-1:0] visited_ff, visited_in;
   logic [DW-1:0]      degree_ff [MAX_VERTICES];
   logic [DW-1:0]      degree_in [MAX_VERTICES];

   logic [NW-1:0]      n_cnt;
   logic [VW-1:0]      deg_addr;
   logic [DW-1:0]      deg_rd;
   logic [VW-1:0]      src_idx, dst_idx;

   logic               nb_we, nb_re;
   logic [AW-1:0]      nb_waddr, nb_raddr;
   logic [VW-1:0]      nb_wdata, nb_rdata;
   logic               pd_we, pd_re;
   logic [VW-1:0]      pd_waddr, pd_raddr;
   logic [PW-1:0]      pd_wdata, pd_rdata;
   logic [VW-1:0]      pd_vtx;
   logic [DW-1:0]      pd_pos;
   logic [VW:0]        top_idx;
   logic               w_ok;

   function automatic logic [AW-1:0] naddr(input logic [VW-1:0] v, input logic [DW-1:0] p);
      naddr = AW'(v) * AW'(MAX_DEGREE) + AW'(p);
   endfunction

   gbt_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES * MAX_DEGREE)) u_nbr_ram (
      .clock   (clock),
      .wr_en   (nb_we),
      .wr_addr (nb_waddr),
      .wr_data (nb_wdata),
      .rd_en   (nb_re),
      .rd_addr (nb_raddr),
      .rd_data (nb_rdata)
   );

   gbt_ram #(.WIDTH(PW), .DEPTH(MAX_VERTICES)) u_pend_ram (
      .clock   (clock),
      .wr_en   (pd_we),
      .wr_addr (pd_waddr),
      .wr_data (pd_wdata),
      .rd_en   (pd_re),
      .rd_addr (pd_raddr),
      .rd_data (pd_rdata)
   );

   assign n_cnt = ({1'b0, vertex_count} < NW'(MAX_VERTICES)) ?
                  {1'b0, vertex_count} : NW'(MAX_VERTICES);
   assign src_idx = VW'(src_ff);
   assign dst_idx = VW'(dst_ff);
   assign pd_vtx  = pd_rdata[PW-1:DW];
   assign pd_pos  = pd_rdata[DW-1:0];
   assign top_idx = tail_ff - (VW+1)'(1);
   assign idle    = (state_ff == S_IDLE);

   always_comb begin
      unique case (state_ff)
         S_ADD_RD:              deg_addr = src_idx;
         S_ADD_CHK, S_ADD_WD:   deg_addr = dst_idx;
         S_D_TOPW:              deg_addr = pd_vtx;
         default:               deg_addr = v_ff;
      endcase
   end
   assign deg_rd = degree_ff[deg_addr];

   // stale or visited neighbors and a full pending store are skipped
   assign w_ok = (NW'(nb_rdata) < n_cnt) && !visited_ff[nb_rdata] &&
                 (tail_ff < (VW+1)'(MAX_VERTICES));

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      src_in      = src_ff;
      dst_in      = dst_ff;
      root_in     = root_ff;
      status_in   = status_ff;
      v_in        = v_ff;
      pos_in      = pos_ff;
      degs_in     = degs_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      cnt_in      = cnt_ff;
      hold_vld_in = hold_vld_ff;
      hold_v_in   = hold_v_ff;
      visited_in  = visited_ff;
      degree_in   = degree_ff;
      nb_we = 1'b0; nb_waddr = '0; nb_wdata = '0;
      nb_re = 1'b0; nb_raddr = '0;
      pd_we = 1'b0; pd_waddr = '0; pd_wdata = '0;
      pd_re = 1'b0; pd_raddr = '0;
      emit = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in    = op;
               src_in   = edge_source;
               dst_in   = edge_destination;
               root_in  = root_vertex;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            case (op_ff)
               OP_ADD: begin
                  if ((NW'(src_ff) >= n_cnt) || (NW'(dst_ff) >= n_cnt)) begin
                     status_in = ST_RANGE;
                     state_in  = S_RESULT;
                  end else begin
                     state_in = S_ADD_RD;
                  end
               end
               OP_BFS, OP_DFS: begin
                  if (NW'(root_ff) >= n_cnt) begin
                     status_in = ST_RANGE;
                     state_in  = S_RESULT;
                  end else begin
                     visited_in = '0;
                     visited_in[VW'(root_ff)] = 1'b1;
                     pd_we    = 1'b1;
                     pd_waddr = '0;
                     pd_wdata = {VW'(root_ff), DW'(0)};
                     head_in  = '0;
                     tail_in  = (VW+1)'(1);
                     if (op_ff == OP_BFS) begin
                        hold_vld_in = 1'b0;
                        cnt_in      = '0;
                        state_in    = S_B_POP;
                     end else begin
                        hold_vld_in = 1'b1;
                        hold_v_in   = VW'(root_ff);
                        cnt_in      = CNT_W'(1);
                        state_in    = S_D_TOP;
                     end
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_ADD_RD: begin
            degs_in  = deg_rd;
            state_in = S_ADD_CHK;
         end
         S_ADD_CHK: begin
            if ((src_ff == dst_ff) ?
                ((DW+1)'(degs_ff) + (DW+1)'(2) > (DW+1)'(MAX_DEGREE)) :
                ((degs_ff >= DW'(MAX_DEGREE)) || (deg_rd >= DW'(MAX_DEGREE)))) begin
               status_in = ST_DROPPED;
               state_in  = S_RESULT;
            end else begin
               nb_we    = 1'b1;
               nb_waddr = naddr(src_idx, degs_ff);
               nb_wdata = dst_idx;
               degree_in[src_idx] = degs_ff + DW'(1);
               state_in = S_ADD_WD;
            end
         end
         S_ADD_WD: begin
            // degree re-read here so a self-loop lands in the next slot
            nb_we    = 1'b1;
            nb_waddr = naddr(dst_idx, deg_rd);
            nb_wdata = src_idx;
            degree_in[dst_idx] = deg_rd + DW'(1);
            status_in = ST_ADDED;
            state_in  = S_RESULT;
         end
         S_RESULT: begin
            if (out_free) begin
               emit.valid  = 1'b1;
               emit.status = status_ff;
               emit.vertex = '0;
               emit.last   = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_B_POP: begin
            if ((head_ff < tail_ff) && (cnt_ff < CNT_W'(RESULT_CAP))) begin
               pd_re    = 1'b1;
               pd_raddr = head_ff[VW-1:0];
               head_in  = head_ff + (VW+1)'(1);
               state_in = S_B_POPW;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_B_POPW: begin
            // previous visit goes out once the next one is known
            if (!hold_vld_ff || out_free) begin
               emit.valid  = hold_vld_ff;
               emit.status = ST_VISIT;
               emit.vertex = FIELD_W'(hold_v_ff);
               hold_vld_in = 1'b1;
               hold_v_in   = pd_vtx;
               cnt_in      = cnt_ff + CNT_W'(1);
               v_in        = pd_vtx;
               pos_in      = '0;
               state_in    = S_B_NREAD;
            end
         end
         S_B_NREAD: begin
            if (pos_ff < deg_rd) begin
               nb_re    = 1'b1;
               nb_raddr = naddr(v_ff, pos_ff);
               pos_in   = pos_ff + DW'(1);
               state_in = S_B_NCHK;
            end else begin
               state_in = S_B_POP;
            end
         end
         S_B_NCHK: begin
            if (w_ok) begin
               visited_in[nb_rdata] = 1'b1;
               pd_we    = 1'b1;
               pd_waddr = tail_ff[VW-1:0];
               pd_wdata = {nb_rdata, DW'(0)};
               tail_in  = tail_ff + (VW+1)'(1);
            end
            state_in = S_B_NREAD;
         end
         S_D_TOP: begin
            if ((tail_ff != '0) && (cnt_ff < CNT_W'(RESULT_CAP))) begin
               pd_re    = 1'b1;
               pd_raddr = top_idx[VW-1:0];
               state_in = S_D_TOPW;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_D_TOPW: begin
            if (pd_pos < deg_rd) begin
               nb_re    = 1'b1;
               nb_raddr = naddr(pd_vtx, pd_pos);
               pd_we    = 1'b1;
               pd_waddr = top_idx[VW-1:0];
               pd_wdata = {pd_vtx, pd_pos + DW'(1)};
               state_in = S_D_NCHK;
            end else begin
               tail_in  = top_idx;
               state_in = S_D_TOP;
            end
         end
         S_D_NCHK: begin
            if (!w_ok) begin
               state_in = S_D_TOP;
            end else if (out_free) begin
               emit.valid  = 1'b1;
               emit.status = ST_VISIT;
               emit.vertex = FIELD_W'(hold_v_ff);
               hold_v_in   = nb_rdata;
               cnt_in      = cnt_ff + CNT_W'(1);
               visited_in[nb_rdata] = 1'b1;
               pd_we    = 1'b1;
               pd_waddr = tail_ff[VW-1:0];
               pd_wdata = {nb_rdata, DW'(0)};
               tail_in  = tail_ff + (VW+1)'(1);
               state_in = S_D_TOP;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               emit.valid  = 1'b1;
               emit.status = ST_VISIT;
               emit.vertex = FIELD_W'(hold_v_ff);
               emit.last   = 1'b1;
               hold_vld_in = 1'b0;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         hold_vld_ff <= 1'b0;
         visited_ff  <= '0;
         head_ff     <= '0;
         tail_ff     <= '0;
         cnt_ff      <= '0;
         for (int i = 0; i < MAX_VERTICES; i++) begin
            degree_ff[i] <= '0;
         end
      end else begin
         state_ff    <= state_in;
         hold_vld_ff <= hold_vld_in;
         visited_ff  <= visited_in;
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         cnt_ff      <= cnt_in;
         degree_ff   <= degree_in;
      end
      op_ff     <= op_in;
      src_ff    <= src_in;
      dst_ff    <= dst_in;
      root_ff   <= root_in;
      status_ff <= status_in;
      v_ff      <= v_in;
      pos_ff    <= pos_in;
      degs_ff   <= degs_in;
      hold_v_ff <= hold_v_in;
   end

endmodule

### src/graph_bfs_dfs_traversal_unit.sv
// Top level: graph traversal unit with configuration register and result register.
//
// Undirected graph engine. An add-edge transaction answers with one status result, as does
// a traversal whose root is out of range. Any other traversal answers with one result per
// visited vertex, the final one flagged last. Both traversals are bounded by the single
// read port of the neighbor RAM, which the sequencer walks one entry at a time. The block
// takes no new transaction until the previous one has been fully answered; a stalled
// result port holds the sequencer. Configuration writes are accepted at any time but must
// only be issued while the unit is idle.
module graph_bfs_dfs_traversal_unit
   import gbt_pkg::*;
#(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF,
   parameter int MAX_DEGREE   = MAX_DEGREE_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [CFG_W-1:0]   csr_vertex_count,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_op,
   input  logic [FIELD_W-1:0] req_edge_source,
   input  logic [FIELD_W-1:0] req_edge_destination,
   input  logic [FIELD_W-1:0] req_root_vertex,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic [FIELD_W-1:0] rsp_vertex,
   output logic               rsp_last
);

   logic [CFG_W-1:0]   vcount_ff;
   logic               rsp_valid_ff;
   logic [1:0]         rsp_status_ff;
   logic [FIELD_W-1:0] rsp_vertex_ff;
   logic               rsp_last_ff;
   logic               idle, out_free;
   emit_type           emit;

   assign csr_ready = 1'b1;
   assign req_stall = !idle;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   gbt_engine #(.MAX_VERTICES(MAX_VERTICES), .MAX_DEGREE(MAX_DEGREE)) u_engine (
      .clock            (clock),
      .reset            (reset),
      .vertex_count     (vcount_ff),
      .start            (req_valid && !req_stall),
      .op               (req_op),
      .edge_source      (req_edge_source),
      .edge_destination (req_edge_destination),
      .root_vertex      (req_root_vertex),
      .idle             (idle),
      .out_free         (out_free),
      .emit             (emit)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff    <= CFG_W'(CFG_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            vcount_ff <= csr_vertex_count;
         end
         if (emit.valid) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (emit.valid) begin
         rsp_status_ff <= emit.status;
         rsp_vertex_ff <= emit.vertex;
         rsp_last_ff   <= emit.last;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_vertex = rsp_vertex_ff;
   assign rsp_last   = rsp_last_ff;

endmodule
